>>> rtl/core/brle_pkg.sv
// Shared types and constants for the byte run-length encoder.
// Holds the input and output transfer structs and the run command type.
// No dependencies.
`default_nettype none

package brle_pkg;

  // Longest run that one length byte can carry.
  localparam logic [7:0] RunMax = 8'd255;

  // Default depth of the command queue between front and back.
  localparam int unsigned DefaultQueueDepth = 4;

  // One input transfer.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       batch_end;
  } in_t;

  // One output transfer.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_batch_end;
  } out_t;

  // A finished run waiting to be serialized.
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] count;
  } run_t;

  // Work for the back end from one input item: an older run that a
  // different byte closed, then the current run if it was closed too.
  typedef struct packed {
    logic old_valid;
    run_t old_run;
    logic new_valid;
    run_t new_run;
    logic batch_end;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/brle_front.sv
// Front end of the run-length encoder: tracks the pending run and turns
// each input item into at most one command for the back end.
// Depends on brle_pkg.
`default_nettype none

module brle_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire brle_pkg::in_t in_data_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output brle_pkg::cmd_t     push_cmd_o
);
  import brle_pkg::*;

  logic [7:0] run_value_q, run_value_d;
  logic [7:0] run_count_q, run_count_d;
  logic       accept;
  logic       flush_old;
  logic       flush_new;
  logic [7:0] next_count;
  logic [7:0] next_value;

  // Any item may enter while the queue has room.
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the item: does it close the old run, and does it close the
  // run it now belongs to.
  always_comb begin
    flush_old = (run_count_q != 8'd0) && (in_data_i.data_byte != run_value_q);
    if (run_count_q == 8'd0 || flush_old) begin
      next_value = in_data_i.data_byte;
      next_count = 8'd1;
    end else begin
      next_value = run_value_q;
      next_count = run_count_q + 8'd1;
    end
    flush_new = (next_count == RunMax) || in_data_i.batch_end;

    run_value_d = run_value_q;
    run_count_d = run_count_q;
    if (accept) begin
      run_value_d = next_value;
      run_count_d = flush_new ? 8'd0 : next_count;
    end

    push_cmd_o.old_valid     = flush_old;
    push_cmd_o.old_run.value = run_value_q;
    push_cmd_o.old_run.count = run_count_q;
    push_cmd_o.new_valid     = flush_new;
    push_cmd_o.new_run.value = next_value;
    push_cmd_o.new_run.count = next_count;
    push_cmd_o.batch_end     = in_data_i.batch_end;
    push_o                   = accept && (flush_old || flush_new);
  end

  // Pending run state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_value_q <= 8'd0;
      run_count_q <= 8'd0;
    end else begin
      run_value_q <= run_value_d;
      run_count_q <= run_count_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/brle_queue.sv
// Small command queue that decouples the encoder front and back ends.
// Register storage with one write and one read place per cycle.
// Depends on brle_pkg.
`default_nettype none

module brle_queue #(
  parameter int unsigned Depth = brle_pkg::DefaultQueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire brle_pkg::cmd_t push_cmd_i,
  input  wire logic           pop_i,
  output brle_pkg::cmd_t      head_o,
  output logic                full_o,
  output logic                empty_o
);
  import brle_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entries_q[rd_ptr_q];

  // Pointer and fill count update, wrapping at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage holds payload only and needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/brle_back.sv
// Back end of the run-length encoder: serializes queued run commands into
// output bytes through a registered output stage.
// Depends on brle_pkg.
`default_nettype none

module brle_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire brle_pkg::cmd_t head_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output brle_pkg::out_t      out_data_o
);
  import brle_pkg::*;

  logic       sel_q, sel_d;   // 0: old run, 1: new run
  logic [1:0] idx_q, idx_d;   // byte position inside the current run
  logic       out_valid_q, out_valid_d;
  out_t       out_q, out_d;
  logic       load;
  logic       sel_eff;
  run_t       cur_run;
  logic       run_done;
  logic       cmd_done;

  // With a command queued, the output register takes a new byte whenever it is empty or drained.
  assign load = !empty_i && (!out_valid_q || out_ready_i);

  // Pick the byte for the current position of the head command.
  always_comb begin
    sel_eff  = sel_q || !head_i.old_valid;
    cur_run  = sel_eff ? head_i.new_run : head_i.old_run;
    run_done = (cur_run.count >= 8'd2) ? (idx_q == 2'd2) : (idx_q == 2'd0);
    cmd_done = run_done && (sel_eff || !head_i.new_valid);

    sel_d       = sel_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d         = 1'b1;
      out_d.out_byte      = (idx_q == 2'd2) ? cur_run.count : cur_run.value;
      out_d.out_last      = cmd_done;
      out_d.out_batch_end = cmd_done && head_i.batch_end;
      if (cmd_done) begin
        pop_o = 1'b1;
        sel_d = 1'b0;
        idx_d = 2'd0;
      end else if (run_done) begin
        sel_d = 1'b1;
        idx_d = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      sel_q       <= sel_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/core/byte_run_length_encoder.sv
// Byte run-length encoder, top level.
// The first output byte of an item passes the command queue and then the
// output register. Throughput: one input transfer per cycle while the queue
// has room, one output byte per cycle while the output is ready; a closed
// run gives one or three output bytes, so the output sets the sustained rate.
// Reset is asynchronous, active low, and clears the pending run and queue.
`default_nettype none

module byte_run_length_encoder #(
  parameter int unsigned QueueDepth = brle_pkg::DefaultQueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire brle_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output brle_pkg::out_t      out_data_o
);
  import brle_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic q_full;
  logic q_empty;

  // Run tracking and classification.
  brle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  // Commands between the two ends.
  brle_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // Byte serialization.
  brle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> bench/tb_byte_run_length_encoder.sv
`timescale 1ns / 1ps
// Testbench for the byte run-length encoder: directed, saturation, stall and random tests.
// The predictor below runs on every accepted input transfer; a checker compares each output transfer.
// Depends on brle_pkg and byte_run_length_encoder.

module tb_byte_run_length_encoder;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 300;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  brle_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  brle_pkg::out_t out_data;

  // Predicted compressed stream, oldest byte first.
  brle_pkg::out_t expected_bytes[$];
  logic [7:0]     run_byte = '0;
  logic [7:0]     run_len = '0;

  int unsigned    errors = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  logic           hold_request = 1'b0;
  int unsigned    quiet_cycles = 0;

  byte_run_length_encoder u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Emit the pending run as a literal or as byte, byte, length, and clear it.
  function automatic void close_run();
    if (run_len >= 8'd2) begin
      expected_bytes.push_back(brle_pkg::out_t'{run_byte, 1'b0, 1'b0});
      expected_bytes.push_back(brle_pkg::out_t'{run_byte, 1'b0, 1'b0});
      expected_bytes.push_back(brle_pkg::out_t'{run_len, 1'b0, 1'b0});
    end else if (run_len == 8'd1) begin
      expected_bytes.push_back(brle_pkg::out_t'{run_byte, 1'b0, 1'b0});
    end
    run_len = '0;
  endfunction

  // Work out the compressed bytes caused by one accepted input byte.
  function automatic void predict_item(input brle_pkg::in_t item);
    int unsigned    first;
    brle_pkg::out_t tail;
    first = expected_bytes.size();
    if (run_len != 0 && item.data_byte != run_byte) begin
      close_run();
    end
    if (run_len == 0) begin
      run_byte = item.data_byte;
      run_len  = 8'd1;
    end else begin
      run_len = run_len + 8'd1;
    end
    if (run_len == brle_pkg::RunMax || item.batch_end) begin
      close_run();
    end
    // The last byte of this item carries the item and batch markers.
    if (expected_bytes.size() > first) begin
      tail = expected_bytes[expected_bytes.size() - 1];
      tail.out_last = 1'b1;
      tail.out_batch_end = item.batch_end;
      expected_bytes[expected_bytes.size() - 1] = tail;
    end
  endfunction

  // Offer one byte, with random idle cycles before it, and wait for its transfer.
  task automatic send_byte(input logic [7:0] b, input logic last_of_batch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= brle_pkg::in_t'{b, last_of_batch};
    do @(posedge clk); while (!in_ready);
    predict_item(in_data);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted byte has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Output side: random stalls, or a long hold-off when one is requested.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each output transfer with the oldest predicted byte.
  always @(posedge clk) begin
    brle_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected output %02h last %0b batch_end %0b", $time,
                 out_data.out_byte, out_data.out_last, out_data.out_batch_end);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %02h got %02h", $time,
                   want.out_byte, out_data.out_byte);
          errors++;
        end
        if (out_data.out_last !== want.out_last) begin
          $display("%0t: out_last expected %0b got %0b", $time,
                   want.out_last, out_data.out_last);
          errors++;
        end
        if (out_data.out_batch_end !== want.out_batch_end) begin
          $display("%0t: out_batch_end expected %0b got %0b", $time,
                   want.out_batch_end, out_data.out_batch_end);
          errors++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row without any transfer ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Field extremes, literals, short runs, run closed by a different byte
  // together with the batch end, and batches that do not merge.
  task automatic test_directed();
    send_idle_pct = 13;
    recv_idle_pct = 77;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b0); send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b0); send_byte(8'h55, 1'b0); send_byte(8'h55, 1'b1);
    send_byte(8'h0F, 1'b0); send_byte(8'h0F, 1'b0); send_byte(8'hF0, 1'b1);
    send_byte(8'h01, 1'b0); send_byte(8'h02, 1'b0); send_byte(8'h04, 1'b0);
    send_byte(8'h08, 1'b0); send_byte(8'h10, 1'b0); send_byte(8'h20, 1'b0);
    send_byte(8'h40, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b1);
    send_byte(8'hFE, 1'b0); send_byte(8'hFE, 1'b0); send_byte(8'hFE, 1'b0);
    send_byte(8'hFE, 1'b1);
    send_byte(8'h33, 1'b1); send_byte(8'h33, 1'b1);
    drain();
  endtask

  // A run that reaches the saturated length, then an equal byte that must start a new run.
  task automatic test_saturation();
    int unsigned k;
    send_idle_pct = 13;
    recv_idle_pct = 77;
    for (k = 0; k < 255; k++) send_byte(8'hC3, 1'b0);
    send_byte(8'hC3, 1'b1);
    drain();
  endtask

  // Hold the output off long enough that the input stalls, then drain completely.
  task automatic test_stall_and_drain();
    int unsigned k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    for (k = 0; k < 24; k++) begin
      send_byte(8'(k * 37 + 1), (k % 6) == 5);
    end
    drain();
  endtask

  // Random batches: mostly short runs with random content, some stray batch ends.
  task automatic test_random(input int unsigned n_items, input int unsigned s_pct,
                             input int unsigned r_pct);
    int unsigned sent;
    int unsigned batch_len;
    int unsigned k;
    logic [7:0]  b;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      batch_len = $urandom_range(1, 12);
      b = 8'($urandom);
      for (k = 1; k <= batch_len; k++) begin
        if ($urandom_range(99) < 45) b = 8'($urandom);
        send_byte(b, (k == batch_len) || ($urandom_range(99) < 5));
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_saturation();
    test_random(20, 13, 77);
    test_random(20, 77, 13);
    test_stall_and_drain();
    test_random(20, 0, 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/brle_pkg.sv
rtl/core/brle_front.sv
rtl/core/brle_queue.sv
rtl/core/brle_back.sv
rtl/core/byte_run_length_encoder.sv
bench/tb_byte_run_length_encoder.sv
